@@ hdl/fir5_valid_line_filter_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the five-tap line filter
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef FIR5_VALID_LINE_FILTER_MACROS_SVH
`define FIR5_VALID_LINE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FVLF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FVLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fvlf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvlf_pkg
// Shared constants, types and reset values for the line filter.
// ---------------------------------------------------------------------------
package fvlf_pkg;

    localparam int TAPS      = 5;
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int PROD_W    = SAMPLE_W + TAP_W;
    localparam int PSUM_W    = PROD_W + 1;
    localparam int SUM_W     = 34;
    localparam int FILL_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NPAIR     = (TAPS + 1) / 2;

    typedef logic signed [PROD_W-1:0] prod_arr_t [TAPS];

    // Control handed to every history cell on an accepted item.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Reset value of each coefficient; taps past the fifth start at zero.
    function automatic logic signed [TAP_W-1:0] tap_reset(input int idx);
        logic signed [TAP_W-1:0] val;
        case (idx)
            0:       val = 16'sd1148;
            1:       val = 16'sd8152;
            2:       val = 16'sd14167;
            3:       val = 16'sd8152;
            4:       val = 16'sd1148;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ hdl/fvlf_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvlf_cell
// One history cell: holds a past sample and registers its tap product.
// ---------------------------------------------------------------------------
module fvlf_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fvlf_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [fvlf_pkg::SAMPLE_W-1:0]  d_in,
    input  logic signed [fvlf_pkg::TAP_W-1:0]     tap,
    output logic signed [fvlf_pkg::SAMPLE_W-1:0]  d_out,
    output logic signed [fvlf_pkg::PROD_W-1:0]    prod
);

    logic signed [fvlf_pkg::SAMPLE_W-1:0] hist_reg;
    logic signed [fvlf_pkg::SAMPLE_W-1:0] hist_next;
    logic signed [fvlf_pkg::PROD_W-1:0]   prod_reg;
    logic signed [fvlf_pkg::PROD_W-1:0]   prod_next;

    // The product uses the sample held before this item shifts in.
    always_comb
    begin
        hist_next = hist_reg;
        prod_next = prod_reg;
        if (ctrl.shift)
        begin
            hist_next = ctrl.clear ? '0 : d_in;
            prod_next = fvlf_pkg::PROD_W'(tap * hist_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign d_out = hist_reg;
    assign prod  = prod_reg;

endmodule

@@ hdl/fvlf_sum.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvlf_sum
// Two-stage adder pipeline: pair sums, then the final 34-bit total.
// ---------------------------------------------------------------------------
module fvlf_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fvlf_pkg::prod_arr_t                 prod,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fvlf_pkg::SUM_W-1:0]   filtered,
    output logic                                line_done
);

    logic signed [fvlf_pkg::PSUM_W-1:0] psum_next [fvlf_pkg::NPAIR];
    logic signed [fvlf_pkg::PSUM_W-1:0] psum_reg  [fvlf_pkg::NPAIR];
    logic                               s2_valid_reg;
    logic                               s2_valid_next;
    logic                               s2_last_reg;
    logic                               s3_valid_reg;
    logic                               s3_valid_next;
    logic                               s3_last_reg;
    logic signed [fvlf_pkg::SUM_W-1:0]  sum_reg;
    logic signed [fvlf_pkg::SUM_W-1:0]  sum_next;
    logic                               s3_ready;
    logic                               s2_load;
    logic                               s3_load;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s3_ready;
    assign s2_load  = in_valid && in_ready;
    assign s3_load  = s2_valid_reg && s3_ready;

    for (genvar j = 0; j < fvlf_pkg::NPAIR; j++)
    begin : g_pair
        if (2 * j + 1 < fvlf_pkg::TAPS)
        begin : g_two
            assign psum_next[j] = fvlf_pkg::PSUM_W'(prod[2 * j])
                                + fvlf_pkg::PSUM_W'(prod[2 * j + 1]);
        end
        else
        begin : g_one
            assign psum_next[j] = fvlf_pkg::PSUM_W'(prod[2 * j]);
        end
    end

    // Sum wraps modulo 2^34, as the result field does.
    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < fvlf_pkg::NPAIR; j++)
        begin
            sum_next = sum_next + fvlf_pkg::SUM_W'(psum_reg[j]);
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (in_ready)
        begin
            s2_valid_next = in_valid;
        end
        s3_valid_next = s3_valid_reg;
        if (s3_ready)
        begin
            s3_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            psum_reg    <= psum_next;
            s2_last_reg <= in_last;
        end
        if (s3_load)
        begin
            sum_reg     <= sum_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign filtered  = sum_reg;
    assign line_done = s3_last_reg;

endmodule

@@ hdl/fir5_valid_line_filter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir5_valid_line_filter
// Five-tap valid-convolution filter over lines of 16-bit samples.
// ---------------------------------------------------------------------------
// While the output does not stall, the block accepts one sample per clock
// and gives one result per clock once a line has seen five samples. Each
// result passes the product registers (tap 0's beside the row of history
// cells, the others in it), the pair-sum register and the final-sum
// register of the adder pipeline. Every sample of a line shifts one place
// down the cell row; the sample marked as the line's last clears the row
// and the fill count, so a line shorter than five samples gives no result
// at all. The result is the full-precision sum of taps times samples with
// 15 fractional bits, and line_done marks the result caused by a line's
// last sample. Coefficients are written through the configuration port;
// the user must do so only while no item is in flight, as the block does
// not enforce it. A write to an index past the last tap is ignored.
// ---------------------------------------------------------------------------
module fir5_valid_line_filter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [fvlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fvlf_pkg::TAP_W-1:0]              cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [fvlf_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                    line_end,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [fvlf_pkg::SUM_W-1:0]       filtered,
    output logic                                    line_done
);

    // Coefficient registers, tap 0 weighting the newest sample.
    logic signed [fvlf_pkg::TAP_W-1:0]    tap_reg  [fvlf_pkg::TAPS];
    logic signed [fvlf_pkg::TAP_W-1:0]    tap_next [fvlf_pkg::TAPS];

    logic [fvlf_pkg::FILL_W-1:0]          fill_reg;
    logic [fvlf_pkg::FILL_W-1:0]          fill_next;
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic                                 s1_last_reg;
    logic signed [fvlf_pkg::PROD_W-1:0]   p0_reg;
    logic signed [fvlf_pkg::SAMPLE_W-1:0] hist [fvlf_pkg::TAPS-1];
    fvlf_pkg::prod_arr_t                  prod;
    fvlf_pkg::cell_ctrl_t                 ctrl;
    logic                                 accept;
    logic                                 produce;
    logic                                 sum_ready;

    // An item produces a result only once the history is full.
    assign produce  = (fill_reg == fvlf_pkg::FILL_W'(fvlf_pkg::TAPS - 1));
    assign in_ready = !s1_valid_reg || sum_ready;
    assign accept   = in_valid && in_ready;

    assign ctrl.shift = accept;
    assign ctrl.clear = accept && line_end;

    always_comb
    begin
        for (int i = 0; i < fvlf_pkg::TAPS; i++)
        begin
            tap_next[i] = tap_reg[i];
            if (cfg_write && (cfg_index == fvlf_pkg::CFG_IDX_W'(i)))
            begin
                tap_next[i] = cfg_data;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (line_end)
            begin
                fill_next = '0;
            end
            else if (!produce)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Stage one holds a result only for items that produce one; it drains
    // when the adder pipeline takes it.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = produce;
        end
        else if (sum_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fvlf_pkg::TAPS; i++)
            begin
                tap_reg[i] <= fvlf_pkg::tap_reset(i);
            end
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            tap_reg      <= tap_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // The newest sample meets tap 0 here; the cells cover the older ones.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_reg      <= fvlf_pkg::PROD_W'(tap_reg[0] * sample);
            s1_last_reg <= line_end;
        end
    end

    assign prod[0] = p0_reg;

    // Row of history cells: cell k holds the sample k+1 places back.
    for (genvar k = 0; k < fvlf_pkg::TAPS - 1; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            fvlf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .d_in  (sample),
                .tap   (tap_reg[k + 1]),
                .d_out (hist[k]),
                .prod  (prod[k + 1])
            );
        end
        else
        begin : g_body
            fvlf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .d_in  (hist[k - 1]),
                .tap   (tap_reg[k + 1]),
                .d_out (hist[k]),
                .prod  (prod[k + 1])
            );
        end
    end

    // Pair sums, then the final total, with the output register last.
    fvlf_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (sum_ready),
        .prod      (prod),
        .in_last   (s1_last_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .line_done (line_done)
    );

endmodule

@@ hdl/fvlf_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fvlf_checker
// Port-level checks of result flow for the line filter.
// ---------------------------------------------------------------------------
`include "fir5_valid_line_filter_macros.svh"

module fvlf_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    line_end,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [fvlf_pkg::SUM_W-1:0]       filtered,
    input  logic                                    line_done
);

    logic [fvlf_pkg::FILL_W-1:0] chk_fill_reg;
    logic [2:0]                  pend_reg;
    logic                        in_acc;
    logic                        out_acc;
    logic                        prod_acc;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign prod_acc = in_acc && (chk_fill_reg == fvlf_pkg::FILL_W'(fvlf_pkg::TAPS - 1));

    // Independent count of samples seen in the line and results in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_fill_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                if (line_end)
                begin
                    chk_fill_reg <= '0;
                end
                else if (!prod_acc)
                begin
                    chk_fill_reg <= chk_fill_reg + 1'b1;
                end
            end
            pend_reg <= pend_reg + {2'b00, prod_acc} - {2'b00, out_acc};
        end
    end

    `FVLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered) && $stable(line_done), "stalled result changed")
    `FVLF_ASSERT_SAME(a_no_extra, out_valid, pend_reg != 3'd0, "result without a full line behind it")
    `FVLF_ASSERT_SAME(a_depth, 1'b1, pend_reg <= 3'd3, "more results in flight than stages")
    `FVLF_ASSERT_NEXT(a_latency, prod_acc ##1 out_ready ##1 out_ready, out_valid, "result late on a free-flowing output")

endmodule

bind fir5_valid_line_filter fvlf_checker u_fvlf_checker (.*);

@@ tb/fir5_line_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir5_line_result_checker
// Watches the filter's channels, predicts each result and compares it.
// ---------------------------------------------------------------------------
// Keeps a private copy of the coefficients, the recent samples of the line
// and the fill count. Every accepted sample updates that copy and, once a
// line holds five samples, queues the expected sum. Every accepted result is
// checked against the oldest queued sum.
// ---------------------------------------------------------------------------
module fir5_line_result_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [fvlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fvlf_pkg::TAP_W-1:0]              cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [fvlf_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                    line_end,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [fvlf_pkg::SUM_W-1:0]       filtered,
    input  logic                                    line_done,
    output int                                      mismatches,
    output int                                      pending
);
    import fvlf_pkg::*;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic                    line_done;
    } line_result_t;

    logic signed [TAP_W-1:0]    coef [TAPS];
    logic signed [SAMPLE_W-1:0] recent [TAPS-1];
    int                         seen;
    int                         failures = 0;
    longint                     acc;
    line_result_t               want;
    line_result_t               expected_sums [$];

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef[0] = 16'sd1148;
            coef[1] = 16'sd8152;
            coef[2] = 16'sd14167;
            coef[3] = 16'sd8152;
            coef[4] = 16'sd1148;
            for (int k = 0; k < TAPS - 1; k++)
                recent[k] = '0;
            seen = 0;
            expected_sums.delete();
            pending <= 0;
        end
        else
        begin
            // Writes past the last tap have no effect.
            if (cfg_write && cfg_index < TAPS)
                coef[cfg_index] = cfg_data;

            if (in_valid && in_ready)
            begin
                if (seen >= TAPS - 1)
                begin
                    acc = longint'(coef[0]) * longint'(sample);
                    for (int k = 1; k < TAPS; k++)
                        acc += longint'(coef[k]) * longint'(recent[k-1]);
                    want.filtered  = acc[SUM_W-1:0];
                    want.line_done = line_end;
                    expected_sums.push_back(want);
                end
                if (line_end)
                begin
                    for (int k = 0; k < TAPS - 1; k++)
                        recent[k] = '0;
                    seen = 0;
                end
                else
                begin
                    for (int k = TAPS - 2; k > 0; k--)
                        recent[k] = recent[k-1];
                    recent[0] = sample;
                    if (seen < TAPS - 1)
                        seen++;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("result with no item waiting: filtered %0d, line_done %0b",
                           filtered, line_done);
                    failures++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (filtered !== want.filtered)
                    begin
                        $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
                        failures++;
                    end
                    if (line_done !== want.line_done)
                    begin
                        $error("line_done: expected %0b, actual %0b",
                               want.line_done, line_done);
                        failures++;
                    end
                end
            end
            pending <= expected_sums.size();
        end
        mismatches <= failures;
    end

endmodule

@@ tb/fir5_valid_line_filter_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir5_valid_line_filter_test
// Regression of the five-tap line filter against an independent predictor.
// ---------------------------------------------------------------------------
// A short directed run covers short lines, a line of exactly five samples,
// full-scale samples and full-scale coefficients, and writes to the unused
// register indexes. Random phases follow, each with its own coefficients,
// feeding lines of random length and content through bursty input timing
// and an output side that stalls on its own pattern, including long
// hold-offs that back the block up. The checker beside the block predicts
// and compares every result; this module only drives and judges.
// ---------------------------------------------------------------------------
module fir5_valid_line_filter_test;
    import fvlf_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    // Wait after the last predicted result so that any item that gives no
    // result has also left the pipeline.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    // Longest honest quiet stretch is the hold-off above; allow ten times.
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 65;

    // Register map of the configuration port. Indexes past the last tap
    // exist on the port but must be ignored by the block.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_0,
        REG_TAP_1,
        REG_TAP_2,
        REG_TAP_3,
        REG_TAP_4,
        REG_SPARE_5,
        REG_SPARE_6,
        REG_SPARE_7
    } cfg_reg_e;

    // Patterns of the output side between long hold-offs.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_BURSTY_STALL
    } rx_pattern_e;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [TAP_W-1:0]           cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       line_end  = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SUM_W-1:0]    filtered;
    logic                       line_done;

    int check_errors;
    int check_pending;
    int burst_left  = 0;
    int idle_cycles = 0;
    // The stimulus asks for a hold-off by raising holds_asked; the receiver
    // process serves it and counts it in holds_taken.
    int holds_asked = 0;
    int holds_taken = 0;

    fir5_valid_line_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .line_end  (line_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .line_done (line_done)
    );

    fir5_line_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filtered   (filtered),
        .line_done  (line_done),
        .mismatches (check_errors),
        .pending    (check_pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("fir5_valid_line_filter regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Extreme or special values four times in ten, otherwise any 16-bit
    // pattern. Used for samples and for coefficients alike.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One write on the configuration port, applied at the next rising edge.
    task automatic write_reg(input cfg_reg_e idx, input logic [TAP_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one sample and return at the edge where it is accepted. The
    // sender works in bursts; at the start of each burst it may first pause
    // with valid low. Valid stays high across back-to-back items.
    task automatic send_item(input logic signed [SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        line_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering, wait until every predicted result has come out, then
    // let the pipeline settle so that items which produce no result have also
    // left it. Only then is the block idle for writes.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (check_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side. It switches between random patterns of ready, and when the
    // stimulus asks, it holds ready low for a long counted stretch so the
    // block fills up and pushes back on its input.
    initial
    begin
        rx_pattern_e rx_mode;
        int          rx_count;
        int          rx_stall_left;
        logic        rx_ready;
        rx_mode       = RX_ALWAYS;
        rx_count      = 0;
        rx_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != holds_asked)
            begin
                holds_taken++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (rx_count % 50 == 0)
                    rx_mode = rx_pattern_e'($urandom_range(0, 3));
                rx_count++;
                case (rx_mode)
                    RX_ALWAYS:      rx_ready = 1'b1;
                    RX_COIN:        rx_ready = 1'($urandom_range(0, 1));
                    RX_ONE_IN_FOUR: rx_ready = (rx_count % 4 == 0);
                    default:
                    begin
                        if (rx_stall_left > 0)
                        begin
                            rx_stall_left--;
                            rx_ready = 1'b0;
                        end
                        else if ($urandom_range(0, 5) == 0)
                        begin
                            rx_stall_left = $urandom_range(1, 8);
                            rx_ready      = 1'b0;
                        end
                        else
                            rx_ready = 1'b1;
                    end
                endcase
                out_ready <= rx_ready;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int          len;
        int          phase_items;
        bit          squeezed;
        logic [15:0] tap_val;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset coefficients. A single-sample line
        // and a four-sample line must give nothing at all.
        send_item(16'sh7FFF, 1'b1);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh0000, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'shFFFF, 1'b1);
        // A line of exactly five samples gives one result, marked as the
        // line's last.
        send_item(16'sd100,  1'b0);
        send_item(-16'sd200, 1'b0);
        send_item(16'sd300,  1'b0);
        send_item(-16'sd400, 1'b0);
        send_item(16'sd500,  1'b1);
        // Full-scale positive run that turns to full-scale negative, so the
        // window slides across the sign change.
        repeat (5) send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh8000, 1'b1);

        // Every tap at the most negative value, and the spare indexes hit
        // with all ones and 7FFF; those writes must leave the taps alone.
        drain_block();
        for (int k = 0; k < TAPS; k++)
            write_reg(cfg_reg_e'(k), 16'h8000);
        write_reg(REG_SPARE_5, 16'hFFFF);
        write_reg(REG_SPARE_6, 16'h7FFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        // Negative taps on negative samples give the largest possible sum;
        // the last sample then flips one product to the other extreme.
        repeat (5) send_item(16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b1);

        // Random phases, each with its own coefficients. The first two use
        // fixed extremes; the rest draw from pick_value.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_block();
            for (int k = 0; k < TAPS; k++)
            begin
                case (phase)
                    0:       tap_val = 16'h7FFF;
                    1:       tap_val = (k % 2 == 0) ? 16'h7FFF : 16'h8000;
                    default: tap_val = pick_value();
                endcase
                write_reg(cfg_reg_e'(k), tap_val);
            end
            write_reg(cfg_reg_e'($urandom_range(TAPS, 7)), 16'($urandom));

            phase_items = 0;
            squeezed    = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                // Mostly lines long enough to give results, some too short,
                // now and then a long one.
                case ($urandom_range(0, 9))
                    0, 1:    len = $urandom_range(1, TAPS - 1);
                    9:       len = $urandom_range(20, 40);
                    default: len = $urandom_range(TAPS, 16);
                endcase
                // Two phases ask for a long output hold-off partway through,
                // while the sender keeps offering.
                if ((phase == 1 || phase == 4) && !squeezed && phase_items >= 20)
                begin
                    squeezed = 1'b1;
                    holds_asked++;
                end
                for (int i = 0; i < len; i++)
                    send_item(pick_value(), i == len - 1);
                phase_items += len;
            end
        end

        drain_block();
        if (check_errors == 0 && check_pending == 0)
            $display("fir5_valid_line_filter regression: pass");
        else
            $display("fir5_valid_line_filter regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fvlf_pkg.sv
hdl/fvlf_cell.sv
hdl/fvlf_sum.sv
hdl/fir5_valid_line_filter.sv
hdl/fvlf_checker.sv
tb/fir5_line_result_checker.sv
tb/fir5_valid_line_filter_test.sv
